FILE: design/sswd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sswd_pkg
// Types and constants shared by the watermark correlator modules.
// ----------------------------------------------------------------------------
package sswd_pkg;

    localparam int unsigned MAX_BLOCK_SAMPLES     = 65535;
    localparam int unsigned MAX_PAYLOAD_POSITIONS = 4096;

    // configuration register indexes
    localparam logic [1:0] REG_SAMPLES_PER_BLOCK = 2'd0;
    localparam logic [1:0] REG_PAYLOAD_LENGTH    = 2'd1;

    // one finished block, handed from the accumulator to the solver
    typedef struct packed {
        logic signed [63:0] corr;
        logic [47:0]        sig_energy;
        logic [47:0]        chip_energy;
        logic [11:0]        position;
        logic [31:0]        block_idx;
    } block_rec_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQUARE,
        BK_PRODUCT,
        BK_NCORR,
        BK_CONF,
        BK_DONE
    } back_state_t;

endpackage

FILE: design/sswd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sswd_fifo
// Two-entry queue of block records between accumulator and solver.
// ----------------------------------------------------------------------------
module sswd_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sswd_pkg::block_rec_t push_data,
    output logic               full,
    input  logic               pop,
    output sswd_pkg::block_rec_t pop_data,
    output logic               empty
);

    sswd_pkg::block_rec_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/sswd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sswd_front
// Takes samples, tracks block/position counters and accumulates correlation,
// signal energy and chip energy; pushes one record per finished block.
// ----------------------------------------------------------------------------
module sswd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        samples_per_block,
    input  logic [12:0]        payload_length,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] left_sample,
    input  logic signed [15:0] right_sample,
    input  logic signed [15:0] pn_chip,
    input  logic               start_of_stream,
    output logic               push,
    output sswd_pkg::block_rec_t push_data,
    input  logic               full
);

    logic [15:0] sample_cnt_reg, sample_cnt_next;
    logic [11:0] pos_reg, pos_next;
    logic [31:0] blk_reg, blk_next;

    // product stage
    logic               p_valid_reg;
    logic               p_end_reg;
    logic               p_sos_reg;
    logic signed [32:0] p_sc_reg;
    logic [32:0]        p_ss_reg;
    logic [30:0]        p_cc_reg;
    logic [11:0]        p_pos_reg;
    logic [31:0]        p_blk_reg;

    // accumulate stage
    logic signed [63:0] corr_reg, corr_next;
    logic [47:0]        sig_reg, sig_next;
    logic [47:0]        chip_reg, chip_next;

    logic               stall;
    logic               accept;
    logic signed [16:0] mid_sum;
    logic [15:0]        blen;
    logic [12:0]        plen;
    logic [15:0]        sc_base;
    logic [11:0]        pos_base;
    logic [31:0]        blk_base;
    logic               blk_end;
    logic signed [63:0] corr_sum;
    logic [47:0]        sig_sum;
    logic [47:0]        chip_sum;

    assign stall    = p_valid_reg && p_end_reg && full;
    assign in_ready = !stall;
    assign accept   = in_valid && in_ready;
    assign mid_sum  = 17'(left_sample) + 17'(right_sample);

    always_comb
    begin
        blen = (samples_per_block > 16'(sswd_pkg::MAX_BLOCK_SAMPLES))
             ? 16'(sswd_pkg::MAX_BLOCK_SAMPLES) : samples_per_block;
        plen = (payload_length > 13'(sswd_pkg::MAX_PAYLOAD_POSITIONS))
             ? 13'(sswd_pkg::MAX_PAYLOAD_POSITIONS) : payload_length;
        sc_base  = start_of_stream ? 16'd0 : sample_cnt_reg;
        pos_base = start_of_stream ? 12'd0 : pos_reg;
        blk_base = start_of_stream ? 32'd0 : blk_reg;
        blk_end  = ({1'b0, sc_base} + 17'd1) >= {1'b0, blen};

        sample_cnt_next = sample_cnt_reg;
        pos_next        = pos_reg;
        blk_next        = blk_reg;
        if (accept)
        begin
            if (blk_end)
            begin
                sample_cnt_next = 16'd0;
                blk_next        = blk_base + 32'd1;
                if (({1'b0, pos_base} + 13'd1) >= plen)
                begin
                    pos_next = 12'd0;
                end
                else
                begin
                    pos_next = pos_base + 12'd1;
                end
            end
            else
            begin
                sample_cnt_next = sc_base + 16'd1;
                pos_next        = pos_base;
                blk_next        = blk_base;
            end
        end
    end

    always_comb
    begin
        corr_sum = (p_sos_reg ? 64'sd0 : corr_reg) + 64'(p_sc_reg);
        sig_sum  = (p_sos_reg ? 48'd0 : sig_reg) + 48'(p_ss_reg);
        chip_sum = (p_sos_reg ? 48'd0 : chip_reg) + 48'(p_cc_reg);

        push                  = p_valid_reg && p_end_reg && !full;
        push_data.corr        = corr_sum;
        push_data.sig_energy  = sig_sum;
        push_data.chip_energy = chip_sum;
        push_data.position    = p_pos_reg;
        push_data.block_idx   = p_blk_reg;

        corr_next = corr_reg;
        sig_next  = sig_reg;
        chip_next = chip_reg;
        if (p_valid_reg && !stall)
        begin
            if (p_end_reg)
            begin
                corr_next = 64'sd0;
                sig_next  = 48'd0;
                chip_next = 48'd0;
            end
            else
            begin
                corr_next = corr_sum;
                sig_next  = sig_sum;
                chip_next = chip_sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_end_reg <= blk_end;
            p_sos_reg <= start_of_stream;
            p_sc_reg  <= 33'(mid_sum * pn_chip);
            p_ss_reg  <= 33'(mid_sum * mid_sum);
            p_cc_reg  <= 31'(pn_chip * pn_chip);
            p_pos_reg <= pos_base;
            p_blk_reg <= blk_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg    <= 1'b0;
            sample_cnt_reg <= 16'd0;
            pos_reg        <= 12'd0;
            blk_reg        <= 32'd0;
            corr_reg       <= 64'sd0;
            sig_reg        <= 48'd0;
            chip_reg       <= 48'd0;
        end
        else
        begin
            if (!stall)
            begin
                p_valid_reg <= accept;
            end
            sample_cnt_reg <= sample_cnt_next;
            pos_reg        <= pos_next;
            blk_reg        <= blk_next;
            corr_reg       <= corr_next;
            sig_reg        <= sig_next;
            chip_reg       <= chip_next;
        end
    end

endmodule

FILE: design/sswd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sswd_back
// Per-block solver: squares and products via a 24x24 multiply-accumulate,
// then bit-by-bit root searches for normalized correlation and confidence.
// ----------------------------------------------------------------------------
module sswd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 empty,
    input  sswd_pkg::block_rec_t pop_data,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 decided_bit,
    output logic signed [31:0]   normalized_correlation,
    output logic [16:0]          confidence,
    output logic [11:0]          payload_position,
    output logic [31:0]          block_index
);

    sswd_pkg::back_state_t state_reg, state_next;
    sswd_pkg::block_rec_t  rec_reg, rec_next;

    logic [47:0]  mag_reg, mag_next;
    logic [95:0]  c2_reg, c2_next;
    logic [95:0]  sp_reg, sp_next;
    logic [1:0]   mcnt_reg, mcnt_next;
    logic [31:0]  q_reg, q_next;
    logic [129:0] a_reg, a_next;
    logic [111:0] bv_reg, bv_next;
    logic [4:0]   bit_reg, bit_next;
    logic [31:0]  ncorr_reg, ncorr_next;
    logic [16:0]  conf_reg, conf_next;

    logic         out_valid_reg, out_valid_next;
    logic         obit_reg;
    logic [31:0]  oncorr_reg;
    logic [16:0]  oconf_reg;
    logic [11:0]  opos_reg;
    logic [31:0]  oblk_reg;
    logic         out_load;

    logic [23:0]  mul_x, mul_y;
    logic [47:0]  mul_p;
    logic [95:0]  mul_term;
    logic [47:0]  mul_a, mul_b;
    logic [129:0] m_ext, r_ext, cand_val;
    logic         cand_ok;
    logic [63:0]  corr_abs;
    logic [31:0]  q_fin;

    assign out_valid              = out_valid_reg;
    assign decided_bit            = obit_reg;
    assign normalized_correlation = oncorr_reg;
    assign confidence             = oconf_reg;
    assign payload_position       = opos_reg;
    assign block_index            = oblk_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sswd_pkg::BK_IDLE:
            begin
                if (!empty)
                begin
                    state_next = sswd_pkg::BK_SQUARE;
                end
            end
            sswd_pkg::BK_SQUARE:
            begin
                if (mcnt_reg == 2'd3)
                begin
                    state_next = sswd_pkg::BK_PRODUCT;
                end
            end
            sswd_pkg::BK_PRODUCT:
            begin
                if (mcnt_reg == 2'd3)
                begin
                    state_next = sswd_pkg::BK_NCORR;
                end
            end
            sswd_pkg::BK_NCORR:
            begin
                if (bit_reg == 5'd0)
                begin
                    state_next = sswd_pkg::BK_CONF;
                end
            end
            sswd_pkg::BK_CONF:
            begin
                if (bit_reg == 5'd0)
                begin
                    state_next = sswd_pkg::BK_DONE;
                end
            end
            sswd_pkg::BK_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = sswd_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = sswd_pkg::BK_IDLE;
            end
        endcase
    end

    // shared 24x24 partial product: lo*lo, lo*hi, hi*lo, hi*hi
    always_comb
    begin
        mul_a = (state_reg == sswd_pkg::BK_SQUARE) ? mag_reg : rec_reg.sig_energy;
        mul_b = (state_reg == sswd_pkg::BK_SQUARE) ? mag_reg : rec_reg.chip_energy;
        mul_x = mcnt_reg[1] ? mul_a[47:24] : mul_a[23:0];
        mul_y = mcnt_reg[0] ? mul_b[47:24] : mul_b[23:0];
        mul_p = mul_x * mul_y;
        case (mcnt_reg)
            2'd0:    mul_term = 96'(mul_p);
            2'd3:    mul_term = {mul_p, 48'd0};
            default: mul_term = {24'd0, mul_p, 24'd0};
        endcase
    end

    // root search: largest q with q*q*M <= R, one bit per cycle
    always_comb
    begin
        if (state_reg == sswd_pkg::BK_NCORR)
        begin
            m_ext = 130'(rec_reg.sig_energy);
            r_ext = 130'(c2_reg);
        end
        else
        begin
            m_ext = 130'(sp_reg);
            r_ext = {2'b00, c2_reg, 32'd0};
        end
        cand_val = a_reg + (130'(bv_reg) << ({1'b0, bit_reg} + 6'd1))
                 + (m_ext << {bit_reg, 1'b0});
        cand_ok  = cand_val <= r_ext;
        q_fin    = cand_ok ? (q_reg | (32'd1 << bit_reg)) : q_reg;
    end

    // datapath
    always_comb
    begin
        rec_next   = rec_reg;
        mag_next   = mag_reg;
        c2_next    = c2_reg;
        sp_next    = sp_reg;
        mcnt_next  = mcnt_reg;
        q_next     = q_reg;
        a_next     = a_reg;
        bv_next    = bv_reg;
        bit_next   = bit_reg;
        ncorr_next = ncorr_reg;
        conf_next  = conf_reg;
        pop        = 1'b0;
        out_load   = 1'b0;
        corr_abs   = pop_data.corr[63] ? (64'd0 - pop_data.corr) : pop_data.corr;

        case (state_reg)
            sswd_pkg::BK_IDLE:
            begin
                if (!empty)
                begin
                    pop       = 1'b1;
                    rec_next  = pop_data;
                    mag_next  = corr_abs[47:0];
                    c2_next   = 96'd0;
                    mcnt_next = 2'd0;
                end
            end
            sswd_pkg::BK_SQUARE:
            begin
                c2_next   = c2_reg + mul_term;
                mcnt_next = mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd3)
                begin
                    sp_next = 96'd0;
                end
            end
            sswd_pkg::BK_PRODUCT:
            begin
                sp_next   = sp_reg + mul_term;
                mcnt_next = mcnt_reg + 2'd1;
                if (mcnt_reg == 2'd3)
                begin
                    q_next   = 32'd0;
                    a_next   = 130'd0;
                    bv_next  = 112'd0;
                    bit_next = 5'd31;
                end
            end
            sswd_pkg::BK_NCORR, sswd_pkg::BK_CONF:
            begin
                q_next   = q_fin;
                bit_next = bit_reg - 5'd1;
                if (cand_ok)
                begin
                    a_next  = cand_val;
                    bv_next = bv_reg + 112'(m_ext << bit_reg);
                end
                if (bit_reg == 5'd0)
                begin
                    q_next   = 32'd0;
                    a_next   = 130'd0;
                    bv_next  = 112'd0;
                    bit_next = 5'd15;
                end
                if (state_reg == sswd_pkg::BK_NCORR && bit_reg == 5'd0)
                begin
                    if (rec_reg.sig_energy == 48'd0)
                    begin
                        ncorr_next = 32'd0;
                    end
                    else if (!rec_reg.corr[63])
                    begin
                        ncorr_next = (q_fin > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_fin;
                    end
                    else
                    begin
                        ncorr_next = 32'd0
                                   - ((q_fin > 32'h8000_0000) ? 32'h8000_0000 : q_fin);
                    end
                end
                if (state_reg == sswd_pkg::BK_CONF && bit_reg == 5'd0)
                begin
                    if (rec_reg.sig_energy == 48'd0 || rec_reg.chip_energy == 48'd0)
                    begin
                        conf_next = 17'd0;
                    end
                    else if (sp_reg <= c2_reg)
                    begin
                        conf_next = 17'd65536;
                    end
                    else
                    begin
                        conf_next = {1'b0, q_fin[15:0]};
                    end
                end
            end
            sswd_pkg::BK_DONE:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
            end
        endcase

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg   <= rec_next;
        mag_reg   <= mag_next;
        c2_reg    <= c2_next;
        sp_reg    <= sp_next;
        mcnt_reg  <= mcnt_next;
        q_reg     <= q_next;
        a_reg     <= a_next;
        bv_reg    <= bv_next;
        bit_reg   <= bit_next;
        ncorr_reg <= ncorr_next;
        conf_reg  <= conf_next;
        if (out_load)
        begin
            obit_reg   <= !rec_reg.corr[63] && (rec_reg.corr != 64'sd0);
            oncorr_reg <= ncorr_reg;
            oconf_reg  <= conf_reg;
            opos_reg   <= rec_reg.position;
            oblk_reg   <= rec_reg.block_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sswd_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: design/spread_spectrum_watermark_detect_top.sv
`timescale 1ns / 1ps
// Samples are taken one per cycle while in_ready is high; a full block result follows the
// block's last sample transfer through the product register, the hand-over into the queue,
// squaring and energy product on the shared 24x24 multiplier, the root searches and the
// output register. The solver works on one block at a time, so with the two-entry queue,
// short blocks can stall input. Reset (async, active low) clears counters, accumulators,
// handshakes; samples_per_block = 4096, payload_length = 464.
// ----------------------------------------------------------------------------
// spread_spectrum_watermark_detect_top
// Spread-spectrum watermark correlator: block correlation, energy, bit decision.
// ----------------------------------------------------------------------------
module spread_spectrum_watermark_detect_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] left_sample,
    input  logic signed [15:0] right_sample,
    input  logic signed [15:0] pn_chip,
    input  logic               start_of_stream,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               decided_bit,
    output logic signed [31:0] normalized_correlation,
    output logic [16:0]        confidence,
    output logic [11:0]        payload_position,
    output logic [31:0]        block_index
);

    logic [15:0] spb_reg;
    logic [12:0] plen_reg;

    logic                 push;
    logic                 pop;
    logic                 full;
    logic                 empty;
    sswd_pkg::block_rec_t push_data;
    sswd_pkg::block_rec_t pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spb_reg  <= 16'd4096;
            plen_reg <= 13'd464;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == sswd_pkg::REG_SAMPLES_PER_BLOCK)
            begin
                spb_reg <= cfg_data;
            end
            else if (cfg_index == sswd_pkg::REG_PAYLOAD_LENGTH)
            begin
                plen_reg <= cfg_data[12:0];
            end
        end
    end

    sswd_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .samples_per_block (spb_reg),
        .payload_length    (plen_reg),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .left_sample       (left_sample),
        .right_sample      (right_sample),
        .pn_chip           (pn_chip),
        .start_of_stream   (start_of_stream),
        .push              (push),
        .push_data         (push_data),
        .full              (full)
    );

    sswd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    sswd_back u_back (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .empty                  (empty),
        .pop_data               (pop_data),
        .pop                    (pop),
        .out_valid              (out_valid),
        .out_ready              (out_ready),
        .decided_bit            (decided_bit),
        .normalized_correlation (normalized_correlation),
        .confidence             (confidence),
        .payload_position       (payload_position),
        .block_index            (block_index)
    );

endmodule
